>>> rtl/bhpc_pkg.sv
// bhpc_pkg: shared types, codes and constants of the hairpin pair classifier
// used by every file under rtl except bhpc_divider; depends on nothing

package bhpc_pkg;

    // parameter defaults
    localparam int MAX_READ_LEN_DEF = 1024;
    localparam int MAX_BINS_DEF     = 64;
    localparam int COUNT_WIDTH_DEF  = 32;

    // port widths
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 160;
    localparam int OUT_USER_W = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // register and field widths
    localparam int CUTOFF_W   = 17;
    localparam int FRAC_W     = 17;
    localparam int MINLEN_W   = 11;
    localparam int BINS_CFG_W = 7;
    localparam int MAXP_W     = 32;
    localparam int OUT_CNT_W  = 11;
    localparam int OUT_BIN_W  = 6;
    localparam int OUT_TOT_W  = 32;
    localparam int FRAC_BITS  = 16;

    // output field positions in tdata
    localparam int OUT_BIN_IDX_LSB = 22;
    localparam int OUT_BIN_CNT_LSB = 28;

    // register indexes
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t REG_HAIRPIN_CUTOFF = 3'd0;
    localparam cfg_idx_t REG_MIN_GOOD_FRAC  = 3'd1;
    localparam cfg_idx_t REG_MIN_LENGTH     = 3'd2;
    localparam cfg_idx_t REG_HIST_BINS      = 3'd3;
    localparam cfg_idx_t REG_INVERT_SEL     = 3'd4;
    localparam cfg_idx_t REG_MAX_PAIRS      = 3'd5;

    // register reset values
    localparam logic [CUTOFF_W-1:0]   CUTOFF_RST    = 17'd62259;
    localparam logic [FRAC_W-1:0]     MIN_FRAC_RST  = 17'd32768;
    localparam logic [MINLEN_W-1:0]   MIN_LEN_RST   = 11'd32;
    localparam logic [BINS_CFG_W-1:0] HIST_BINS_RST = 7'd20;
    localparam logic                  INVERT_RST    = 1'b0;
    localparam logic [MAXP_W-1:0]     MAX_PAIRS_RST = 32'hFFFF_FFFF;

    // pair class codes
    typedef logic [1:0] pair_class_t;
    localparam pair_class_t CLASS_SKIP    = 2'd0;
    localparam pair_class_t CLASS_NORMAL  = 2'd1;
    localparam pair_class_t CLASS_HAIRPIN = 2'd2;
    localparam pair_class_t CLASS_LIMIT   = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic lim_chk;
        logic qual;
        logic div_start;
        logic ratio_ld;
        logic bin_mul;
        logic bin_clamp;
        logic hist_rd;
        logic hist_wr;
        logic emit;
    } bhpc_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic limit;
        logic qual_fail;
        logic div_done;
    } bhpc_sts_t;

endpackage

>>> rtl/bhpc_divider.sv
// bhpc_divider: restoring divider, one quotient bit per cycle
// depends on nothing; used by bhpc_datapath

module bhpc_divider #(
    parameter int DIVIDEND_W = 27,
    parameter int DIVISOR_W  = 11
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic [DIVIDEND_W-1:0] quotient,
    output logic                  done
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  den_reg, den_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;

    logic [DIVISOR_W:0] trial;
    logic [DIVISOR_W:0] diff;
    logic               fits;

    assign trial = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = (trial >= {1'b0, den_reg});

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            den_next  = divisor;
            cnt_next  = CNT_W'(DIVIDEND_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (cnt_reg != '0)
            begin
                // remainder stays below the divisor, so its top bit drops
                rem_next = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
                quo_next = {quo_reg[DIVIDEND_W-2:0], fits};
                cnt_next = cnt_reg - 1'b1;
            end
            else
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign quotient = quo_reg;
    assign done     = busy_reg && (cnt_reg == '0);

endmodule

>>> rtl/bhpc_datapath.sv
// bhpc_datapath: per-pair counters, quality check, ratio, histogram and result register
// depends on bhpc_pkg and bhpc_divider; driven by bhpc_ctrl commands

module bhpc_datapath #(
    parameter int MAX_READ_LEN = bhpc_pkg::MAX_READ_LEN_DEF,
    parameter int MAX_BINS     = bhpc_pkg::MAX_BINS_DEF,
    parameter int COUNT_WIDTH  = bhpc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  bhpc_pkg::bhpc_cmd_t               cmd,
    output bhpc_pkg::bhpc_sts_t               sts,
    input  logic [bhpc_pkg::IN_DATA_W-1:0]    s_tdata,
    input  logic                              cfg_we,
    input  logic [bhpc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bhpc_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic [bhpc_pkg::OUT_DATA_W-1:0]   m_tdata,
    output logic [bhpc_pkg::OUT_USER_W-1:0]   m_tuser
);

    localparam int LW  = $clog2(MAX_READ_LEN + 1);
    localparam int VW  = $clog2(2 * MAX_READ_LEN + 1);
    localparam int RW  = LW + bhpc_pkg::FRAC_BITS;
    localparam int BW  = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int BNW = $clog2(MAX_BINS + 1);
    localparam int CW  = COUNT_WIDTH;
    localparam int MLW = (LW > bhpc_pkg::MINLEN_W) ? LW : bhpc_pkg::MINLEN_W;
    localparam int CMW = (CW > bhpc_pkg::MAXP_W) ? CW : bhpc_pkg::MAXP_W;
    localparam int QPW = VW + bhpc_pkg::FRAC_W;
    localparam int BPW = RW + BNW;
    localparam int BRW = BPW - bhpc_pkg::FRAC_BITS;

    localparam logic [LW-1:0] LEN_CAP = LW'(MAX_READ_LEN);
    localparam logic [VW-1:0] VS_CAP  = VW'(2 * MAX_READ_LEN);

    localparam logic [7:0] CH_UA = 8'h41;
    localparam logic [7:0] CH_UC = 8'h43;
    localparam logic [7:0] CH_UG = 8'h47;
    localparam logic [7:0] CH_UT = 8'h54;
    localparam logic [7:0] CH_UN = 8'h4E;
    localparam logic [7:0] CH_LA = 8'h61;
    localparam logic [7:0] CH_LC = 8'h63;
    localparam logic [7:0] CH_LG = 8'h67;
    localparam logic [7:0] CH_LT = 8'h74;

    function automatic logic is_base(input logic [7:0] c);
        return (c == CH_UA) || (c == CH_UC) || (c == CH_UG) || (c == CH_UT) ||
               (c == CH_LA) || (c == CH_LC) || (c == CH_LG) || (c == CH_LT);
    endfunction

    // bisulfite-tolerant match, case-sensitive
    function automatic logic bs_match(input logic [7:0] a, input logic [7:0] b);
        return ((a != CH_UN) && (a == b)) || ((a == CH_UT) && (b == CH_UC)) ||
               ((a == CH_UG) && (b == CH_UA));
    endfunction

    function automatic logic [LW-1:0] len_inc(input logic [LW-1:0] v);
        return (v < LEN_CAP) ? v + 1'b1 : LEN_CAP;
    endfunction

    function automatic logic [VW-1:0] vs_inc(input logic [VW-1:0] v);
        return (v < VS_CAP) ? v + 1'b1 : VS_CAP;
    endfunction

    function automatic logic [CW-1:0] cnt_inc(input logic [CW-1:0] v);
        return (v == {CW{1'b1}}) ? v : v + 1'b1;
    endfunction

    // input fields
    logic [7:0] base_one, base_two;
    logic       one_present, two_present;

    assign base_one    = s_tdata[7:0];
    assign one_present = s_tdata[8];
    assign base_two    = s_tdata[16:9];
    assign two_present = s_tdata[17];

    // configuration
    logic [bhpc_pkg::CUTOFF_W-1:0]   cutoff_reg;
    logic [bhpc_pkg::FRAC_W-1:0]     min_frac_reg;
    logic [bhpc_pkg::MINLEN_W-1:0]   min_len_reg;
    logic [bhpc_pkg::BINS_CFG_W-1:0] hist_bins_reg;
    logic                            invert_reg;
    logic [bhpc_pkg::MAXP_W-1:0]     max_pairs_reg;

    // per-pair accumulators and counters
    logic [LW-1:0] len_one_reg, len_one_next;
    logic [LW-1:0] len_two_reg, len_two_next;
    logic [VW-1:0] valid_sum_reg, valid_sum_next;
    logic [LW-1:0] match_reg, match_next;
    logic [LW-1:0] compared_reg, compared_next;
    logic [CW-1:0] pairs_reg, pairs_next;
    logic [CW-1:0] usable_reg, usable_next;
    logic [CW-1:0] hairpin_reg, hairpin_next;
    logic [MAX_BINS-1:0] hist_vld_reg, hist_vld_next;

    // working registers of the end-of-pair sequence
    logic                   limit_reg;
    logic [QPW-1:0]         qprod_reg;
    logic [RW-1:0]          ratio_reg;
    logic [BPW-1:0]         binprod_reg;
    logic                   hp_reg;
    logic [BW-1:0]          bin_reg;
    logic [CW-1:0]          bcount_reg;
    bhpc_pkg::pair_class_t  class_reg;
    logic                   keep_reg;
    logic [CW-1:0]          hist_rd_reg;
    logic                   hit_reg;
    logic [CW-1:0]          hist_mem [MAX_BINS];

    // result register
    bhpc_pkg::pair_class_t           out_class_reg;
    logic                            out_keep_reg;
    logic [bhpc_pkg::OUT_CNT_W-1:0]  out_match_reg;
    logic [bhpc_pkg::OUT_CNT_W-1:0]  out_cmp_reg;
    logic [bhpc_pkg::OUT_BIN_W-1:0]  out_bin_reg;
    logic [bhpc_pkg::OUT_TOT_W-1:0]  out_bcount_reg;
    logic [bhpc_pkg::OUT_TOT_W-1:0]  out_total_reg;
    logic [bhpc_pkg::OUT_TOT_W-1:0]  out_usable_reg;
    logic [bhpc_pkg::OUT_TOT_W-1:0]  out_hairpin_reg;

    // combinational helpers
    logic           valid_one, valid_two;
    logic [VW-1:0]  vs_mid;
    logic [VW-1:0]  len_sum;
    logic           qual_fail;
    logic [RW-1:0]  quotient;
    logic           div_done;
    logic [BNW-1:0] bins_eff;
    logic [BRW-1:0] bin_raw;
    logic [BRW-1:0] bin_max;
    logic [BW-1:0]  bin_clamped;
    logic [CW-1:0]  hist_new;

    assign valid_one = is_base(base_one);
    assign valid_two = is_base(base_two);
    assign vs_mid    = (one_present && valid_one) ? vs_inc(valid_sum_reg) : valid_sum_reg;
    assign len_sum   = VW'(len_one_reg) + VW'(len_two_reg);

    assign qual_fail = (QPW'({valid_sum_reg, {bhpc_pkg::FRAC_BITS{1'b0}}}) < qprod_reg) ||
                       (MLW'(len_one_reg) < MLW'(min_len_reg)) ||
                       (MLW'(len_two_reg) < MLW'(min_len_reg));

    assign sts.limit     = limit_reg;
    assign sts.qual_fail = qual_fail;
    assign sts.div_done  = div_done;

    bhpc_divider #(
        .DIVIDEND_W (RW),
        .DIVISOR_W  (LW)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend ({match_reg, {bhpc_pkg::FRAC_BITS{1'b0}}}),
        .divisor  (compared_reg),
        .quotient (quotient),
        .done     (div_done)
    );

    // hist_bins clamped to 1..MAX_BINS
    always_comb
    begin
        if (hist_bins_reg == '0)
            bins_eff = BNW'(1);
        else if (int'(hist_bins_reg) > MAX_BINS)
            bins_eff = BNW'(MAX_BINS);
        else
            bins_eff = BNW'(hist_bins_reg);
    end

    assign bin_raw     = binprod_reg[BPW-1:bhpc_pkg::FRAC_BITS];
    assign bin_max     = BRW'(bins_eff - 1'b1);
    assign bin_clamped = (bin_raw > bin_max) ? BW'(bin_max) : BW'(bin_raw);
    assign hist_new    = cnt_inc(hit_reg ? hist_rd_reg : '0);

    always_comb
    begin
        len_one_next   = len_one_reg;
        len_two_next   = len_two_reg;
        valid_sum_next = valid_sum_reg;
        match_next     = match_reg;
        compared_next  = compared_reg;
        pairs_next     = pairs_reg;
        usable_next    = usable_reg;
        hairpin_next   = hairpin_reg;
        hist_vld_next  = hist_vld_reg;

        if (cmd.accept)
        begin
            if (one_present)
                len_one_next = len_inc(len_one_reg);
            if (two_present)
                len_two_next = len_inc(len_two_reg);
            valid_sum_next = (two_present && valid_two) ? vs_inc(vs_mid) : vs_mid;
            if (one_present && two_present)
            begin
                if (bs_match(base_one, base_two))
                    match_next = len_inc(match_reg);
                if (valid_one && valid_two)
                    compared_next = len_inc(compared_reg);
            end
        end
        else if (cmd.emit)
        begin
            len_one_next   = '0;
            len_two_next   = '0;
            valid_sum_next = '0;
            match_next     = '0;
            compared_next  = '0;
        end

        if (cmd.qual && !limit_reg)
            pairs_next = cnt_inc(pairs_reg);
        if (cmd.div_start)
            usable_next = cnt_inc(usable_reg);
        if (cmd.hist_wr)
        begin
            hist_vld_next[bin_reg] = 1'b1;
            if (hp_reg)
                hairpin_next = cnt_inc(hairpin_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cutoff_reg    <= bhpc_pkg::CUTOFF_RST;
            min_frac_reg  <= bhpc_pkg::MIN_FRAC_RST;
            min_len_reg   <= bhpc_pkg::MIN_LEN_RST;
            hist_bins_reg <= bhpc_pkg::HIST_BINS_RST;
            invert_reg    <= bhpc_pkg::INVERT_RST;
            max_pairs_reg <= bhpc_pkg::MAX_PAIRS_RST;
            len_one_reg   <= '0;
            len_two_reg   <= '0;
            valid_sum_reg <= '0;
            match_reg     <= '0;
            compared_reg  <= '0;
            pairs_reg     <= '0;
            usable_reg    <= '0;
            hairpin_reg   <= '0;
            hist_vld_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    bhpc_pkg::REG_HAIRPIN_CUTOFF: cutoff_reg    <= cfg_data[16:0];
                    bhpc_pkg::REG_MIN_GOOD_FRAC:  min_frac_reg  <= cfg_data[16:0];
                    bhpc_pkg::REG_MIN_LENGTH:     min_len_reg   <= cfg_data[10:0];
                    bhpc_pkg::REG_HIST_BINS:      hist_bins_reg <= cfg_data[6:0];
                    bhpc_pkg::REG_INVERT_SEL:     invert_reg    <= cfg_data[0];
                    bhpc_pkg::REG_MAX_PAIRS:      max_pairs_reg <= cfg_data;
                    default: ;
                endcase
            end
            len_one_reg   <= len_one_next;
            len_two_reg   <= len_two_next;
            valid_sum_reg <= valid_sum_next;
            match_reg     <= match_next;
            compared_reg  <= compared_next;
            pairs_reg     <= pairs_next;
            usable_reg    <= usable_next;
            hairpin_reg   <= hairpin_next;
            hist_vld_reg  <= hist_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.lim_chk)
        begin
            limit_reg <= (CMW'(pairs_reg) >= CMW'(max_pairs_reg));
            qprod_reg <= QPW'(min_frac_reg) * QPW'(len_sum);
        end
        if (cmd.qual)
        begin
            // classes skip and limit carry no bin and no keep
            class_reg  <= limit_reg ? bhpc_pkg::CLASS_LIMIT : bhpc_pkg::CLASS_SKIP;
            keep_reg   <= 1'b0;
            bin_reg    <= '0;
            bcount_reg <= '0;
        end
        if (cmd.ratio_ld)
            ratio_reg <= (compared_reg == '0) ? '0 : quotient;
        if (cmd.bin_mul)
        begin
            binprod_reg <= BPW'(ratio_reg) * BPW'(bins_eff);
            hp_reg      <= (ratio_reg > RW'(cutoff_reg));
        end
        if (cmd.bin_clamp)
            bin_reg <= bin_clamped;
        if (cmd.hist_rd)
        begin
            hist_rd_reg <= hist_mem[bin_reg];
            hit_reg     <= hist_vld_reg[bin_reg];
        end
        if (cmd.hist_wr)
        begin
            hist_mem[bin_reg] <= hist_new;
            bcount_reg        <= hist_new;
            class_reg         <= hp_reg ? bhpc_pkg::CLASS_HAIRPIN : bhpc_pkg::CLASS_NORMAL;
            keep_reg          <= ~(hp_reg ^ invert_reg);
        end
        if (cmd.emit)
        begin
            out_class_reg   <= class_reg;
            out_keep_reg    <= keep_reg;
            out_match_reg   <= bhpc_pkg::OUT_CNT_W'(match_reg);
            out_cmp_reg     <= bhpc_pkg::OUT_CNT_W'(compared_reg);
            out_bin_reg     <= bhpc_pkg::OUT_BIN_W'(bin_reg);
            out_bcount_reg  <= bhpc_pkg::OUT_TOT_W'(bcount_reg);
            out_total_reg   <= bhpc_pkg::OUT_TOT_W'(pairs_reg);
            out_usable_reg  <= bhpc_pkg::OUT_TOT_W'(usable_reg);
            out_hairpin_reg <= bhpc_pkg::OUT_TOT_W'(hairpin_reg);
        end
    end

    assign m_tdata = {4'b0, out_hairpin_reg, out_usable_reg, out_total_reg, out_bcount_reg,
                      out_bin_reg, out_cmp_reg, out_match_reg};
    assign m_tuser = {out_keep_reg, out_class_reg};

endmodule

>>> rtl/bhpc_ctrl.sv
// bhpc_ctrl: sequencer for base accumulation and the end-of-pair steps
// depends on bhpc_pkg; drives bhpc_datapath through bhpc_cmd_t

module bhpc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    input  logic                s_tlast,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  bhpc_pkg::bhpc_sts_t sts,
    output bhpc_pkg::bhpc_cmd_t cmd
);

    typedef enum logic [8:0] {
        S_ACC   = 9'b000000001,
        S_LIM   = 9'b000000010,
        S_QUAL  = 9'b000000100,
        S_DIV   = 9'b000001000,
        S_BIN   = 9'b000010000,
        S_CLAMP = 9'b000100000,
        S_RD    = 9'b001000000,
        S_WR    = 9'b010000000,
        S_EMIT  = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_ACC:
            begin
                cmd.accept = s_tvalid;
                if (s_tvalid && s_tlast)
                    state_next = S_LIM;
            end
            S_LIM:
            begin
                cmd.lim_chk = 1'b1;
                state_next  = S_QUAL;
            end
            S_QUAL:
            begin
                cmd.qual = 1'b1;
                if (sts.limit || sts.qual_fail)
                    state_next = S_EMIT;
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                if (sts.div_done)
                begin
                    cmd.ratio_ld = 1'b1;
                    state_next   = S_BIN;
                end
            end
            S_BIN:
            begin
                cmd.bin_mul = 1'b1;
                state_next  = S_CLAMP;
            end
            S_CLAMP:
            begin
                cmd.bin_clamp = 1'b1;
                state_next    = S_RD;
            end
            S_RD:
            begin
                cmd.hist_rd = 1'b1;
                state_next  = S_WR;
            end
            S_WR:
            begin
                cmd.hist_wr = 1'b1;
                state_next  = S_EMIT;
            end
            S_EMIT:
            begin
                // wait for room in the result register
                if (out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_ACC;
                end
            end
            default:
            begin
                state_next = S_ACC;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.emit)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_ACC;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == S_ACC);
    assign m_tvalid = out_valid_reg;

endmodule

>>> rtl/bisulfite_hairpin_pair_classifier.sv
// bisulfite_hairpin_pair_classifier: top level of the hairpin pair classifier
// depends on bhpc_pkg, bhpc_ctrl, bhpc_datapath (and bhpc_divider below it)
//
// usage
//   slave stream: one item per aligned base position of a read pair, tlast on
//   the final position. every item is taken in one cycle while a pair streams.
//   master stream: one result item per pair, issued after its last item.
//   config port: cfg_we/cfg_index/cfg_data, written while the block is idle.
// end of pair
//   after the last item of a pair, s_tready stays low while the end-of-pair
//   steps run: the limit check and the quality check, then, for a usable
//   pair, the bit-serial divider for the match ratio, one quotient bit a
//   cycle, the bin multiply, the bin clamp and a read-modify-write of the
//   histogram memory. skipped and over-limit pairs go from the quality check
//   straight to the result; m_tvalid rises as s_tready comes back high.
// reset
//   clears the configuration to its defaults, the counters, the per-pair
//   accumulators and the histogram valid bits; every bin reads as zero.
// stall
//   a result waits in the output register while m_tready is low; the next pair
//   streams in meanwhile and its own result waits until the register frees.

module bisulfite_hairpin_pair_classifier #(
    parameter int MAX_READ_LEN = bhpc_pkg::MAX_READ_LEN_DEF,
    parameter int MAX_BINS     = bhpc_pkg::MAX_BINS_DEF,
    parameter int COUNT_WIDTH  = bhpc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // base_one[7:0], one_present[8], base_two[16:9], two_present[17], zero[23:18]
    input  logic [bhpc_pkg::IN_DATA_W-1:0]  s_tdata,
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // match_count[10:0], compared_count[21:11], bin_index[27:22], bin_count[59:28],
    // total_pairs[91:60], usable_pairs[123:92], hairpin_total[155:124], zero[159:156]
    output logic [bhpc_pkg::OUT_DATA_W-1:0] m_tdata,
    // pair_class[1:0], keep[2]
    output logic [bhpc_pkg::OUT_USER_W-1:0] m_tuser,
    input  logic                            cfg_we,
    input  logic [bhpc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bhpc_pkg::CFG_DATA_W-1:0] cfg_data
);

    bhpc_pkg::bhpc_cmd_t cmd;
    bhpc_pkg::bhpc_sts_t sts;

    bhpc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bhpc_datapath #(
        .MAX_READ_LEN (MAX_READ_LEN),
        .MAX_BINS     (MAX_BINS),
        .COUNT_WIDTH  (COUNT_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .s_tdata   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

>>> rtl/bhpc_checker.sv
// bhpc_checker: port-level assertions for the hairpin pair classifier
// depends on bhpc_pkg; bound to bisulfite_hairpin_pair_classifier

module bhpc_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            s_tlast,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [bhpc_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic [bhpc_pkg::OUT_USER_W-1:0] m_tuser
);

    logic [1:0]                      res_class;
    logic                            res_keep;
    logic [bhpc_pkg::OUT_BIN_W-1:0]  res_bin;
    logic [bhpc_pkg::OUT_TOT_W-1:0]  res_bcount;

    assign res_class  = m_tuser[1:0];
    assign res_keep   = m_tuser[2];
    assign res_bin    = m_tdata[bhpc_pkg::OUT_BIN_IDX_LSB +: bhpc_pkg::OUT_BIN_W];
    assign res_bcount = m_tdata[bhpc_pkg::OUT_BIN_CNT_LSB +: bhpc_pkg::OUT_TOT_W];

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // the end-of-pair steps keep the input closed
    a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input open right after last item");

    // a new result only comes out of the end-of-pair sequence
    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared while accumulating");

    // skipped and over-limit pairs carry no bin and are never kept
    a_unused_fields: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (res_class == bhpc_pkg::CLASS_SKIP || res_class == bhpc_pkg::CLASS_LIMIT)
        |-> !res_keep && (res_bin == '0) && (res_bcount == '0))
        else $error("bin fields set for an unclassified pair");

endmodule

bind bisulfite_hairpin_pair_classifier bhpc_checker u_bhpc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

>>> test/bisulfite_hairpin_pair_classifier_tb.sv
// bisulfite_hairpin_pair_classifier_tb: self-checking bench for the hairpin pair classifier
// streams aligned base items against a local pair predictor, checks every result item;
// depends on bhpc_pkg and the rtl top level

module bisulfite_hairpin_pair_classifier_tb;

    localparam int RUN_LIMIT   = 500000;
    localparam int SETTLE_CYC  = 64;
    localparam int SHORT_ITEMS = 1330;
    localparam int READ_CAP    = 1024;
    localparam int BIN_CAP     = 64;

    typedef struct packed {
        logic [7:0] b1;
        logic       p1;
        logic [7:0] b2;
        logic       p2;
        logic       lst;
    } base_pos_t;

    typedef struct packed {
        bhpc_pkg::pair_class_t cls;
        logic        keep;
        logic [10:0] match_cnt;
        logic [10:0] compared;
        logic [5:0]  bin;
        logic [31:0] bin_cnt;
        logic [31:0] pairs;
        logic [31:0] usable;
        logic [31:0] hairpins;
    } pair_result_t;

    typedef struct packed {
        base_pos_t    pos;
        logic         typed;
        pair_result_t want;
    } dir_row_t;

    logic                            clk;
    logic                            rst_n     = 1'b0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [bhpc_pkg::IN_DATA_W-1:0]  s_tdata   = '0;
    logic                            s_tlast   = 1'b0;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [bhpc_pkg::OUT_DATA_W-1:0] m_tdata;
    logic [bhpc_pkg::OUT_USER_W-1:0] m_tuser;
    logic                            cfg_we    = 1'b0;
    logic [bhpc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [bhpc_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    // register shadow
    logic [bhpc_pkg::CUTOFF_W-1:0]   sh_cutoff    = bhpc_pkg::CUTOFF_RST;
    logic [bhpc_pkg::FRAC_W-1:0]     sh_min_frac  = bhpc_pkg::MIN_FRAC_RST;
    logic [bhpc_pkg::MINLEN_W-1:0]   sh_min_len   = bhpc_pkg::MIN_LEN_RST;
    logic [bhpc_pkg::BINS_CFG_W-1:0] sh_bins      = bhpc_pkg::HIST_BINS_RST;
    logic                            sh_invert    = bhpc_pkg::INVERT_RST;
    logic [bhpc_pkg::MAXP_W-1:0]     sh_max_pairs = bhpc_pkg::MAX_PAIRS_RST;

    // predictor state
    logic [10:0] acc_len1 = '0, acc_len2 = '0, acc_match = '0, acc_cmp = '0;
    logic [11:0] acc_valid = '0;
    logic [31:0] pairs_seen = '0, usable_seen = '0, hairpins_seen = '0;
    logic [31:0] hist_cnt [BIN_CAP];

    pair_result_t pending_pair_results[$];
    dir_row_t     dir_rows[$];

    int  err_cnt     = 0;
    int  rx_count    = 0;
    int  rx_hold     = 0;
    int  short_items = 0;
    int  cycle_cnt   = 0;
    bit  tx_calm     = 1'b0;

    bisulfite_hairpin_pair_classifier u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic bit is_acgt(logic [7:0] c);
        return c == "A" || c == "C" || c == "G" || c == "T" ||
               c == "a" || c == "c" || c == "g" || c == "t";
    endfunction

    // bisulfite conversion lets T pair with C and G pair with A
    function automatic bit bs_tolerant(logic [7:0] a, logic [7:0] b);
        return (a != "N" && a == b) || (a == "T" && b == "C") || (a == "G" && b == "A");
    endfunction

    task automatic classify_position(input base_pos_t p, output bit emits,
                                     output pair_result_t r);
        logic [63:0] ratio;
        logic [63:0] binv;
        logic [63:0] nbins;
        logic [63:0] lhs;
        logic [63:0] rhs;
        r = '0;
        emits = 1'b0;
        if (p.p1)
        begin
            if (acc_len1 < READ_CAP) acc_len1 = acc_len1 + 1'b1;
            if (is_acgt(p.b1) && acc_valid < 2 * READ_CAP) acc_valid = acc_valid + 1'b1;
        end
        if (p.p2)
        begin
            if (acc_len2 < READ_CAP) acc_len2 = acc_len2 + 1'b1;
            if (is_acgt(p.b2) && acc_valid < 2 * READ_CAP) acc_valid = acc_valid + 1'b1;
        end
        if (p.p1 && p.p2)
        begin
            if (bs_tolerant(p.b1, p.b2) && acc_match < READ_CAP)
                acc_match = acc_match + 1'b1;
            if (is_acgt(p.b1) && is_acgt(p.b2) && acc_cmp < READ_CAP)
                acc_cmp = acc_cmp + 1'b1;
        end
        if (p.lst)
        begin
            emits = 1'b1;
            if (pairs_seen >= sh_max_pairs)
                r.cls = bhpc_pkg::CLASS_LIMIT;
            else
            begin
                if (pairs_seen != '1) pairs_seen = pairs_seen + 1'b1;
                lhs = 64'(acc_valid) << 16;
                rhs = 64'(sh_min_frac) * (64'(acc_len1) + 64'(acc_len2));
                if (lhs < rhs || acc_len1 < sh_min_len || acc_len2 < sh_min_len)
                    r.cls = bhpc_pkg::CLASS_SKIP;
                else
                begin
                    nbins = (sh_bins == 0) ? 64'd1 : (sh_bins > BIN_CAP) ? 64'(BIN_CAP) :
                            64'(sh_bins);
                    if (usable_seen != '1) usable_seen = usable_seen + 1'b1;
                    ratio = (acc_cmp == 0) ? 64'd0 : (64'(acc_match) << 16) / 64'(acc_cmp);
                    binv = (ratio * nbins) >> 16;
                    if (binv > nbins - 1) binv = nbins - 1;
                    if (hist_cnt[binv[5:0]] != '1)
                        hist_cnt[binv[5:0]] = hist_cnt[binv[5:0]] + 1'b1;
                    r.bin = binv[5:0];
                    r.bin_cnt = hist_cnt[binv[5:0]];
                    if (ratio > 64'(sh_cutoff))
                    begin
                        if (hairpins_seen != '1) hairpins_seen = hairpins_seen + 1'b1;
                        r.cls = bhpc_pkg::CLASS_HAIRPIN;
                        r.keep = sh_invert;
                    end
                    else
                    begin
                        r.cls = bhpc_pkg::CLASS_NORMAL;
                        r.keep = ~sh_invert;
                    end
                end
            end
            r.match_cnt = acc_match;
            r.compared  = acc_cmp;
            r.pairs     = pairs_seen;
            r.usable    = usable_seen;
            r.hairpins  = hairpins_seen;
            acc_len1  = '0;
            acc_len2  = '0;
            acc_valid = '0;
            acc_match = '0;
            acc_cmp   = '0;
        end
    endtask

    task automatic report_mismatch(string field, logic [31:0] got_v, logic [31:0] want_v);
        $display("result %0d: %s got %0d expected %0d", rx_count, field, got_v, want_v);
        err_cnt++;
    endtask

    // one register write per edge; caller lowers cfg_we after the batch
    task automatic put_reg(bhpc_pkg::cfg_idx_t idx, logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            bhpc_pkg::REG_HAIRPIN_CUTOFF: sh_cutoff    = val[bhpc_pkg::CUTOFF_W-1:0];
            bhpc_pkg::REG_MIN_GOOD_FRAC:  sh_min_frac  = val[bhpc_pkg::FRAC_W-1:0];
            bhpc_pkg::REG_MIN_LENGTH:     sh_min_len   = val[bhpc_pkg::MINLEN_W-1:0];
            bhpc_pkg::REG_HIST_BINS:      sh_bins      = val[bhpc_pkg::BINS_CFG_W-1:0];
            bhpc_pkg::REG_INVERT_SEL:     sh_invert    = val[0];
            bhpc_pkg::REG_MAX_PAIRS:      sh_max_pairs = val[bhpc_pkg::MAXP_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_regs(logic [31:0] cut, logic [31:0] frac, logic [31:0] minlen,
                            logic [31:0] nbins, logic [31:0] inv, logic [31:0] maxp);
        put_reg(bhpc_pkg::REG_HAIRPIN_CUTOFF, cut);
        put_reg(bhpc_pkg::REG_MIN_GOOD_FRAC, frac);
        put_reg(bhpc_pkg::REG_MIN_LENGTH, minlen);
        put_reg(bhpc_pkg::REG_HIST_BINS, nbins);
        put_reg(bhpc_pkg::REG_INVERT_SEL, inv);
        put_reg(bhpc_pkg::REG_MAX_PAIRS, maxp);
        cfg_we <= 1'b0;
    endtask

    task automatic send_pos(base_pos_t p, bit typed, pair_result_t want);
        int           gap;
        bit           emits;
        pair_result_t r;
        gap = tx_calm ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, p.p2, p.b2, p.p1, p.b1};
        s_tlast  <= p.lst;
        do @(posedge clk); while (!s_tready);
        classify_position(p, emits, r);
        if (emits) pending_pair_results.push_back(typed ? want : r);
    endtask

    // wait for every expected result, then for the block to go idle
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_pair_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    function automatic logic [7:0] pick_base();
        int r;
        r = $urandom_range(0, 99);
        case ($urandom_range(0, 3))
            0: pick_base = (r < 70) ? 8'("A") : (r < 82) ? 8'("a") : 8'("N");
            1: pick_base = (r < 70) ? 8'("C") : (r < 82) ? 8'("c") : 8'("N");
            2: pick_base = (r < 70) ? 8'("G") : (r < 82) ? 8'("g") : 8'("N");
            default: pick_base = (r < 70) ? 8'("T") : (r < 82) ? 8'("t") : 8'("N");
        endcase
        if (r >= 90) pick_base = 8'($urandom_range(0, 255));
    endfunction

    // read two mostly copies read one after conversion; miss_pct sets the mismatch rate
    task automatic send_pair(int len1, int len2, int miss_pct, int extra, output int n);
        base_pos_t p;
        n = ((len1 > len2) ? len1 : len2) + extra;
        if (n == 0) n = 1;
        tx_calm = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < n; i++)
        begin
            p.p1 = (i < len1);
            p.p2 = (i < len2);
            p.b1 = p.p1 ? pick_base() : 8'($urandom_range(0, 255));
            if (!p.p2)
                p.b2 = 8'($urandom_range(0, 255));
            else if ($urandom_range(0, 99) < miss_pct)
                p.b2 = pick_base();
            else if (p.b1 == "T" && $urandom_range(0, 1) == 1)
                p.b2 = "C";
            else if (p.b1 == "G" && $urandom_range(0, 1) == 1)
                p.b2 = "A";
            else
                p.b2 = p.b1;
            p.lst = (i == n - 1);
            send_pos(p, 1'b0, '0);
        end
    endtask

    task automatic run_pairs(int budget, int lmin, int lmax);
        int sent;
        int n;
        int len1;
        int len2;
        int miss;
        sent = 0;
        while (sent < budget)
        begin
            len1 = $urandom_range(lmin, lmax);
            len2 = ($urandom_range(0, 3) != 0) ? len1 : $urandom_range(lmin, lmax);
            miss = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 100) : $urandom_range(0, 15);
            send_pair(len1, len2, miss, ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0,
                      n);
            sent += n;
        end
        short_items += sent;
    endtask

    function automatic dir_row_t pos_only(logic [7:0] b1, int p1, logic [7:0] b2, int p2);
        dir_row_t r;
        r.pos   = '{b1, 1'(p1), b2, 1'(p2), 1'b0};
        r.typed = 1'b0;
        r.want  = '0;
        return r;
    endfunction

    function automatic dir_row_t pos_last(logic [7:0] b1, int p1, logic [7:0] b2, int p2);
        dir_row_t r;
        r = pos_only(b1, p1, b2, p2);
        r.pos.lst = 1'b1;
        return r;
    endfunction

    function automatic dir_row_t pos_last_want(logic [7:0] b1, int p1, logic [7:0] b2,
                                               int p2, bhpc_pkg::pair_class_t cls, int keep,
                                               int m, int c, int bin, int bc,
                                               int tot, int usable, int hp);
        dir_row_t r;
        r = pos_last(b1, p1, b2, p2);
        r.typed = 1'b1;
        r.want  = '{cls, 1'(keep), 11'(m), 11'(c), 6'(bin), 32'(bc), 32'(tot), 32'(usable),
                    32'(hp)};
        return r;
    endfunction

    initial
    begin : stimulus
        int n;
        for (int i = 0; i < BIN_CAP; i++) hist_cnt[i] = '0;

        // rows assume min_length 1 and every other register at reset
        dir_rows.push_back(pos_last_want("A", 1, "A", 1, bhpc_pkg::CLASS_HAIRPIN, 0,
                                         1, 1, 19, 1, 1, 1, 1));
        dir_rows.push_back(pos_last_want("A", 1, "C", 1, bhpc_pkg::CLASS_NORMAL, 1,
                                         0, 1, 0, 1, 2, 2, 1));
        // N never counts as valid or as a match
        dir_rows.push_back(pos_last_want("N", 1, "N", 1, bhpc_pkg::CLASS_SKIP, 0,
                                         0, 0, 0, 0, 3, 2, 1));
        // no position with both bases: zero denominator gives ratio 0
        dir_rows.push_back(pos_only("A", 1, "C", 0));
        dir_rows.push_back(pos_last_want("G", 0, "T", 1, bhpc_pkg::CLASS_NORMAL, 1,
                                         0, 0, 0, 2, 4, 3, 1));
        // equal invalid bases match, ratio above one, good fraction exactly at the edge
        dir_rows.push_back(pos_only("x", 1, "x", 1));
        dir_rows.push_back(pos_last_want("A", 1, "A", 1, bhpc_pkg::CLASS_HAIRPIN, 0,
                                         2, 1, 19, 2, 5, 4, 2));
        // conversions match, reversed and lower case do not
        dir_rows.push_back(pos_only("T", 1, "C", 1));
        dir_rows.push_back(pos_only("G", 1, "A", 1));
        dir_rows.push_back(pos_only("C", 1, "T", 1));
        dir_rows.push_back(pos_last_want("t", 1, "c", 1, bhpc_pkg::CLASS_NORMAL, 1,
                                         2, 4, 10, 1, 6, 5, 2));
        // empty pair fails the length test
        dir_rows.push_back(pos_last_want(8'h00, 0, 8'h00, 0, bhpc_pkg::CLASS_SKIP, 0,
                                         0, 0, 0, 0, 7, 5, 2));
        dir_rows.push_back(pos_only(8'hFF, 1, 8'h00, 1));
        dir_rows.push_back(pos_last_want(8'h00, 1, 8'hFF, 1, bhpc_pkg::CLASS_SKIP, 0,
                                         0, 0, 0, 0, 8, 5, 2));
        dir_rows.push_back(pos_only("g", 1, "g", 1));
        dir_rows.push_back(pos_only("a", 1, "A", 0));
        dir_rows.push_back(pos_last("C", 1, "T", 1));
        dir_rows.push_back(pos_only("N", 1, "A", 1));
        dir_rows.push_back(pos_last("G", 1, "A", 1));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        put_reg(bhpc_pkg::REG_MIN_LENGTH, 32'd1);
        cfg_we <= 1'b0;
        foreach (dir_rows[i])
            send_pos(dir_rows[i].pos, dir_rows[i].typed, dir_rows[i].want);
        settle();

        set_regs(32'd62259, 32'd32768, 32'd32, 32'd20, 32'd0, 32'hFFFF_FFFF);
        run_pairs(40, 28, 48);
        settle();

        // receiver holds off long here so the block fills and stalls its input
        set_regs(32'd0, 32'd0, 32'd0, 32'd1, 32'd1, 32'hFFFF_FFFF);
        rx_hold = 400;
        run_pairs(60, 0, 12);
        settle();

        set_regs(32'd65536, 32'd65536, 32'd3, 32'd64, 32'd0, 32'hFFFF_FFFF);
        run_pairs(30, 3, 20);
        settle();

        // zero bins clamps to one
        set_regs(32'd49152, 32'd16384, 32'd2, 32'd0, 32'd1, 32'hFFFF_FFFF);
        run_pairs(25, 1, 16);
        settle();

        set_regs(32'd30000, 32'd40000, 32'd1, 32'd127, 32'd0, pairs_seen + 32'd6);
        run_pairs(25, 1, 14);
        settle();

        set_regs(32'd0, 32'd0, 32'd0, 32'd64, 32'd1, 32'd0);
        run_pairs(15, 0, 8);
        settle();

        // reads past the length cap saturate
        set_regs(32'd65536, 32'd0, 32'd1024, 32'd64, 32'd1, 32'hFFFF_FFFF);
        send_pair(1030, 1027, 5, 0, n);
        short_items += n;
        run_pairs(10, 1, 5);
        settle();

        while (short_items < SHORT_ITEMS)
        begin
            set_regs($urandom_range(0, 65536), $urandom_range(0, 45000), $urandom_range(0, 8),
                     $urandom_range(0, 127), $urandom_range(0, 1),
                     ($urandom_range(0, 3) == 0) ? pairs_seen + $urandom_range(0, 8)
                                                 : 32'hFFFF_FFFF);
            run_pairs($urandom_range(60, 120), 0, $urandom_range(6, 20));
            settle();
        end

        if (err_cnt == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin : result_checker
        int           wait_cyc;
        int           rx_calm;
        pair_result_t got;
        pair_result_t want;
        rx_calm = 0;
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (rx_hold > 0)
            begin
                wait_cyc = rx_hold;
                rx_hold  = 0;
            end
            else if (rx_calm > 0)
            begin
                wait_cyc = 0;
                rx_calm--;
            end
            else
            begin
                wait_cyc = $urandom_range(0, 19);
                if ($urandom_range(0, 7) == 0) rx_calm = $urandom_range(4, 12);
            end
            if (wait_cyc > 0)
            begin
                m_tready <= 1'b0;
                repeat (wait_cyc) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            got.cls       = m_tuser[1:0];
            got.keep      = m_tuser[2];
            got.match_cnt = m_tdata[10:0];
            got.compared  = m_tdata[21:11];
            got.bin       = m_tdata[27:22];
            got.bin_cnt   = m_tdata[59:28];
            got.pairs     = m_tdata[91:60];
            got.usable    = m_tdata[123:92];
            got.hairpins  = m_tdata[155:124];
            if (pending_pair_results.size() == 0)
                report_mismatch("unexpected result, pair_class", 32'(got.cls), 32'd0);
            else
            begin
                want = pending_pair_results.pop_front();
                if (got.cls != want.cls)
                    report_mismatch("pair_class", 32'(got.cls), 32'(want.cls));
                if (got.keep != want.keep)
                    report_mismatch("keep", 32'(got.keep), 32'(want.keep));
                if (got.match_cnt != want.match_cnt)
                    report_mismatch("match_count", 32'(got.match_cnt), 32'(want.match_cnt));
                if (got.compared != want.compared)
                    report_mismatch("compared_count", 32'(got.compared), 32'(want.compared));
                if (got.bin != want.bin)
                    report_mismatch("bin_index", 32'(got.bin), 32'(want.bin));
                if (got.bin_cnt != want.bin_cnt)
                    report_mismatch("bin_count", got.bin_cnt, want.bin_cnt);
                if (got.pairs != want.pairs)
                    report_mismatch("total_pairs", got.pairs, want.pairs);
                if (got.usable != want.usable)
                    report_mismatch("usable_pairs", got.usable, want.usable);
                if (got.hairpins != want.hairpins)
                    report_mismatch("hairpin_total", got.hairpins, want.hairpins);
            end
            rx_count++;
        end
    end

    initial
    begin : watchdog
        while (cycle_cnt < RUN_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("Verification failed");
        $finish;
    end

endmodule

>>> bisulfite_hairpin_pair_classifier.f
rtl/bhpc_pkg.sv
rtl/bhpc_divider.sv
rtl/bhpc_datapath.sv
rtl/bhpc_ctrl.sv
rtl/bisulfite_hairpin_pair_classifier.sv
rtl/bhpc_checker.sv
test/bisulfite_hairpin_pair_classifier_tb.sv
